FILE: rtl/elevator_order_table_stop_logic_defines.svh
// Assertion macros used by the checker file of the elevator order table.
// Depends on nothing; include by bare file name.
`ifndef ELEVATOR_ORDER_TABLE_STOP_LOGIC_DEFINES_SVH
`define ELEVATOR_ORDER_TABLE_STOP_LOGIC_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define EOTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("eots assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define EOTS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("eots assertion failed");

`endif

FILE: rtl/eots_pkg.sv
// Package of the elevator order table: sizes, operation codes and types.
// Used by every RTL module and interface of the block; depends on nothing.
package eots_pkg;

	localparam int FLOORS = 4;
	localparam int IDX_W = (FLOORS > 1) ? $clog2(FLOORS) : 1;

	localparam int FIELD_W = 2;
	localparam int ORDER_W = 3;

	localparam logic [FIELD_W-1:0] OP_ADD   = 2'd0;
	localparam logic [FIELD_W-1:0] OP_QUERY = 2'd1;
	localparam logic [FIELD_W-1:0] OP_CLEAR = 2'd2;

	localparam logic [FIELD_W-1:0] ORDER_UP     = 2'd0;
	localparam logic [FIELD_W-1:0] ORDER_INSIDE = 2'd1;
	localparam logic [FIELD_W-1:0] ORDER_DOWN   = 2'd2;

	localparam logic [FIELD_W-1:0] DIR_UP   = 2'd0;
	localparam logic [FIELD_W-1:0] DIR_DOWN = 2'd1;

	typedef logic [FLOORS-1:0][ORDER_W-1:0] map_t;

	typedef struct packed {
		logic [FIELD_W-1:0] opcode;
		logic [FIELD_W-1:0] floor;
		logic [FIELD_W-1:0] call_kind;
		logic [FIELD_W-1:0] direction;
	} item_t;

	typedef struct packed {
		logic               stop_here;
		logic               was_duplicate;
		logic [ORDER_W-1:0] cleared_lamps;
		logic               any_orders;
		logic [FIELD_W-1:0] highest_floor;
		logic [FIELD_W-1:0] lowest_floor;
	} result_t;

	typedef struct packed {
		logic             any;
		logic [IDX_W-1:0] hi;
		logic [IDX_W-1:0] lo;
	} summary_t;

	typedef struct packed {
		logic               dup;
		logic [ORDER_W-1:0] lamps;
	} store_resp_t;

endpackage

FILE: rtl/eots_item_if.sv
// Valid/ready channel that carries one input item of the order table.
// Depends on eots_pkg.
interface eots_item_if;
	logic           valid;
	logic           ready;
	eots_pkg::item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/eots_result_if.sv
// Valid/ready channel that carries one result item of the order table.
// Depends on eots_pkg.
interface eots_result_if;
	logic              valid;
	logic              ready;
	eots_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/eots_store.sv
// Order bitmap register with its add and clear update logic.
// Depends on eots_pkg.
module eots_store (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  exec,
	input  eots_pkg::item_t       item,
	output eots_pkg::map_t        map_next,
	output eots_pkg::store_resp_t resp
);

	eots_pkg::map_t                map_q;
	logic [eots_pkg::IDX_W-1:0]    idx;
	logic                          floor_ok;
	logic [eots_pkg::ORDER_W-1:0]  bit_sel;

	assign idx      = eots_pkg::IDX_W'(item.floor);
	assign floor_ok = int'(item.floor) < eots_pkg::FLOORS;
	assign bit_sel  = eots_pkg::ORDER_W'(3'b001 << item.call_kind);

	always_comb begin
		map_next = map_q;
		resp     = '0;
		if (floor_ok) begin
			case (item.opcode)
				eots_pkg::OP_ADD: begin
					// Call kind three is not an order and leaves the map alone.
					if (item.call_kind <= eots_pkg::ORDER_DOWN) begin
						resp.dup      = |(map_q[idx] & bit_sel);
						map_next[idx] = map_q[idx] | bit_sel;
					end
				end
				eots_pkg::OP_CLEAR: begin
					resp.lamps    = map_q[idx];
					map_next[idx] = '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q <= '0;
		end else if (exec) begin
			map_q <= map_next;
		end
	end

endmodule

FILE: rtl/eots_summary.sv
// Priority encoders that find whether any order exists and the highest and
// lowest floors holding one. Depends on eots_pkg.
module eots_summary (
	input  eots_pkg::map_t     map,
	output eots_pkg::summary_t summ
);

	always_comb begin
		summ.any = 1'b0;
		summ.hi  = '0;
		summ.lo  = eots_pkg::IDX_W'(eots_pkg::FLOORS - 1);
		for (int i = 0; i < eots_pkg::FLOORS; i++) begin
			if (map[i] != '0) begin
				summ.any = 1'b1;
				summ.hi  = eots_pkg::IDX_W'(i);
			end
		end
		for (int i = eots_pkg::FLOORS - 1; i >= 0; i--) begin
			if (map[i] != '0) begin
				summ.lo = eots_pkg::IDX_W'(i);
			end
		end
	end

endmodule

FILE: rtl/eots_decide.sv
// Stop decision for a query: inside orders always stop, hall calls against
// the travel direction are skipped while orders lie further on. Depends on eots_pkg.
module eots_decide (
	input  eots_pkg::item_t    item,
	input  eots_pkg::map_t     map,
	input  eots_pkg::summary_t summ,
	output logic               stop
);

	logic [eots_pkg::IDX_W-1:0]   idx;
	logic [eots_pkg::ORDER_W-1:0] entry;
	logic                         floor_ok;
	logic                         up_skip;
	logic                         down_skip;

	assign idx      = eots_pkg::IDX_W'(item.floor);
	assign floor_ok = int'(item.floor) < eots_pkg::FLOORS;
	assign entry    = map[idx];

	// An up-call is passed by while heading down with orders still below.
	assign up_skip = (item.direction == eots_pkg::DIR_DOWN) && (idx != '0)
		&& (idx > summ.lo);
	// A down-call is passed by while heading up with orders still above.
	assign down_skip = (item.direction == eots_pkg::DIR_UP)
		&& (idx != eots_pkg::IDX_W'(eots_pkg::FLOORS - 1)) && (idx < summ.hi);

	assign stop = (item.opcode == eots_pkg::OP_QUERY) && floor_ok
		&& (entry[eots_pkg::ORDER_INSIDE]
		|| (entry[eots_pkg::ORDER_UP] && !up_skip)
		|| (entry[eots_pkg::ORDER_DOWN] && !down_skip));

endmodule

FILE: rtl/elevator_order_table_stop_logic.sv
// Elevator order table with stop logic. Orders live in a bitmap of three
// bits per floor (hall up, inside cabin, hall down), so repeated orders merge.
// Each input transfer carries one operation: add an order (reports whether it
// was already stored), query whether to stop at a floor given the previous
// travel direction, or clear a floor (reports the lamps to switch off). Every
// operation yields exactly one result transfer, which also reports whether any
// order remains and the highest and lowest ordered floors (0 and the top floor
// when the table is empty). Throughput is one item per clock cycle while the
// receiver is ready. An item is held in the input register and its result is
// loaded into the result register as the item moves on, which presents the
// result to the receiver. The bitmap is updated as the result is registered so
// the next item sees it. A stalled result holds the result register, and input
// transfers stop once the input register is also full.
// Depends on eots_pkg, eots_item_if, eots_result_if, eots_store, eots_summary
// and eots_decide.
module elevator_order_table_stop_logic (
	input  logic                 clk,
	input  logic                 arst_n,
	eots_item_if.sink            req,
	eots_result_if.source        rsp
);

	// Input register stage.
	eots_pkg::item_t       item_s1;
	logic                  valid_s1;

	// Result register.
	eots_pkg::result_t     res_q;
	logic                  rsp_valid_q;

	eots_pkg::map_t        map_next;
	eots_pkg::store_resp_t store_resp;
	eots_pkg::summary_t    summ;
	logic                  stop;
	logic                  advance;
	eots_pkg::result_t     res_d;

	// The item in the input register moves on whenever the result register is
	// empty or is being emptied in this cycle.
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			item_s1 <= req.data;
		end
	end

	// The bitmap commits only when the item's result is registered.
	eots_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.exec     (advance),
		.item     (item_s1),
		.map_next (map_next),
		.resp     (store_resp)
	);

	// A query leaves the map unchanged, so the summary of the updated map
	// serves both the stop decision and the reported summary.
	eots_summary u_summary (
		.map  (map_next),
		.summ (summ)
	);

	eots_decide u_decide (
		.item (item_s1),
		.map  (map_next),
		.summ (summ),
		.stop (stop)
	);

	always_comb begin
		res_d.stop_here     = stop;
		res_d.was_duplicate = store_resp.dup;
		res_d.cleared_lamps = store_resp.lamps;
		res_d.any_orders    = summ.any;
		res_d.highest_floor = eots_pkg::FIELD_W'(summ.hi);
		res_d.lowest_floor  = eots_pkg::FIELD_W'(summ.lo);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = res_q;

endmodule

FILE: rtl/eots_checker.sv
// Port-level checks of the elevator order table and the bind that attaches them.
// Depends on eots_pkg and elevator_order_table_stop_logic_defines.svh.
`include "elevator_order_table_stop_logic_defines.svh"

module eots_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input eots_pkg::result_t rsp_data
);

	logic empty_ok;
	logic span_ok;
	logic flagged;

	// An empty table reports floor 0 as highest and the top floor as lowest.
	assign empty_ok = (rsp_data.highest_floor == '0)
		&& (rsp_data.lowest_floor == eots_pkg::FIELD_W'(eots_pkg::FLOORS - 1));
	assign span_ok  = rsp_data.lowest_floor <= rsp_data.highest_floor;
	assign flagged  = rsp_data.was_duplicate || rsp_data.stop_here;

	`EOTS_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)
	`EOTS_ASSERT_IMP(a_empty_summary, clk, arst_n, rsp_valid && !rsp_data.any_orders, empty_ok)
	`EOTS_ASSERT_IMP(a_order_span, clk, arst_n, rsp_valid && rsp_data.any_orders, span_ok)
	`EOTS_ASSERT_IMP(a_one_kind, clk, arst_n, rsp_valid && flagged, rsp_data.cleared_lamps == '0)

endmodule

bind elevator_order_table_stop_logic eots_checker u_eots_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
